@@ hw/rtl/corey_pkg.sv @@
// corey_pkg: shared types and constants for the corey relative permeability evaluator
// no dependencies; used by every design module of the block (not corey_chk) by scoped names
package corey_pkg;

    localparam int SAT_W     = 18;
    localparam int RESID_W   = 16;
    localparam int INV_W     = 24;
    localparam int INV_REG_W = 25;
    localparam int KR_W      = 17;
    localparam int DKL_W     = 31;
    localparam int DKG_W     = 32;
    localparam int ADDR_W    = 2;

    typedef enum logic [ADDR_W-1:0] {
        REG_RESID_LIQUID = 2'd0,
        REG_RESID_GAS    = 2'd1,
        REG_INV_SPAN     = 2'd2
    } cfg_reg_t;

    // per-item control that travels with the data
    typedef struct packed {
        logic valid;
        logic err;
        logic window;
    } flags_t;

endpackage

@@ hw/rtl/corey_cfg.sv @@
// corey_cfg: configuration registers (residuals and reciprocal span)
// depends on corey_pkg
module corey_cfg #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [corey_pkg::ADDR_W-1:0]         cfg_wr_addr,
    input  logic [corey_pkg::INV_W-1:0]          cfg_wr_data,
    output logic [corey_pkg::RESID_W-1:0]        resid_liquid,
    output logic [corey_pkg::RESID_W-1:0]        resid_gas,
    output logic [corey_pkg::INV_REG_W-1:0]      inv_span
);

    // one in the fixed point format; needs the extra bit at the widest format
    localparam logic [corey_pkg::INV_REG_W-1:0] INV_RESET =
        corey_pkg::INV_REG_W'(64'd1 << FRAC_BITS);

    logic [corey_pkg::RESID_W-1:0]   resid_liquid_reg;
    logic [corey_pkg::RESID_W-1:0]   resid_gas_reg;
    logic [corey_pkg::INV_REG_W-1:0] inv_span_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resid_liquid_reg <= '0;
            resid_gas_reg    <= '0;
            inv_span_reg     <= INV_RESET;
        end else if (cfg_wr_en) begin
            case (corey_pkg::cfg_reg_t'(cfg_wr_addr))
                corey_pkg::REG_RESID_LIQUID: begin
                    resid_liquid_reg <= cfg_wr_data[corey_pkg::RESID_W-1:0];
                end
                corey_pkg::REG_RESID_GAS: begin
                    resid_gas_reg <= cfg_wr_data[corey_pkg::RESID_W-1:0];
                end
                corey_pkg::REG_INV_SPAN: begin
                    inv_span_reg <= {1'b0, cfg_wr_data};
                end
                default: begin
                end
            endcase
        end
    end

    assign resid_liquid = resid_liquid_reg;
    assign resid_gas    = resid_gas_reg;
    assign inv_span     = inv_span_reg;

endmodule

@@ hw/rtl/corey_scale.sv @@
// corey_scale: stages 1-2, effective saturation s = (S - residual) * inv_span, clamped
// depends on corey_pkg
module corey_scale #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [corey_pkg::SAT_W-1:0]     sat,
    input  logic [corey_pkg::RESID_W-1:0]          resid_liquid,
    input  logic [corey_pkg::RESID_W-1:0]          resid_gas,
    input  logic [corey_pkg::INV_REG_W-1:0]        inv_span,
    output corey_pkg::flags_t                      flg_o,
    output logic signed [FRAC_BITS+3:0]            s_o,
    output logic signed [FRAC_BITS+3:0]            t_o
);

    localparam int SW  = FRAC_BITS + 4;
    localparam int DW  = corey_pkg::SAT_W + 1;
    localparam int MW  = DW + corey_pkg::INV_REG_W + 1;
    localparam int PW  = (2 * FRAC_BITS + 5 > MW) ? 2 * FRAC_BITS + 5 : MW;
    localparam int CW  = (FRAC_BITS + 3 > DW) ? FRAC_BITS + 3 : DW;

    localparam logic signed [CW-1:0] ONE_C = CW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PW-1:0] S_MAX = PW'(64'sd4 <<< FRAC_BITS);
    localparam logic signed [PW-1:0] S_MIN = -S_MAX;
    localparam logic signed [SW-1:0] ONE_S = SW'(64'sd1 <<< FRAC_BITS);

    // stage 1
    logic signed [CW-1:0] sat_x;
    logic signed [CW-1:0] rl_x;
    logic signed [CW-1:0] gas_lim;
    logic signed [DW-1:0] diff;
    logic signed [MW-1:0] prod;
    corey_pkg::flags_t    flg1_next;
    corey_pkg::flags_t    flg1_reg;
    logic signed [MW-1:0] prod_reg;

    assign sat_x   = CW'(sat);
    assign rl_x    = CW'($signed({1'b0, resid_liquid}));
    assign gas_lim = ONE_C - CW'($signed({1'b0, resid_gas}));
    assign diff    = $signed({sat[corey_pkg::SAT_W-1], sat})
                   - $signed({3'b000, resid_liquid});
    assign prod    = diff * $signed({1'b0, inv_span});

    always_comb begin
        flg1_next.valid  = in_valid;
        flg1_next.err    = (sat_x < 0) || (sat_x > ONE_C);
        flg1_next.window = (sat_x > rl_x) && (sat_x < gas_lim);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flg1_reg <= '0;
        end else if (en) begin
            flg1_reg <= flg1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod;
        end
    end

    // stage 2: floor shift and clamp to [-4, 4]
    logic signed [PW-1:0] p_x;
    logic signed [PW-1:0] p_sh;
    logic signed [PW-1:0] s_cl;
    logic signed [SW-1:0] s_next;
    logic signed [SW-1:0] t_next;
    corey_pkg::flags_t    flg2_reg;
    logic signed [SW-1:0] s_reg;
    logic signed [SW-1:0] t_reg;

    assign p_x  = PW'(prod_reg);
    assign p_sh = p_x >>> FRAC_BITS;

    always_comb begin
        if (p_sh > S_MAX) begin
            s_cl = S_MAX;
        end else if (p_sh < S_MIN) begin
            s_cl = S_MIN;
        end else begin
            s_cl = p_sh;
        end
        s_next = s_cl[SW-1:0];
        t_next = ONE_S - s_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flg2_reg <= '0;
        end else if (en) begin
            flg2_reg <= flg1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg <= s_next;
            t_reg <= t_next;
        end
    end

    assign flg_o = flg2_reg;
    assign s_o   = s_reg;
    assign t_o   = t_reg;

endmodule

@@ hw/rtl/corey_poly.sv @@
// corey_poly: stages 3-4, powers and products of s and 1-s
// depends on corey_pkg
module corey_poly #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  corey_pkg::flags_t             flg_i,
    input  logic signed [FRAC_BITS+3:0]   s_i,
    input  logic signed [FRAC_BITS+3:0]   t_i,
    output corey_pkg::flags_t             flg_o,
    output logic signed [FRAC_BITS+9:0]   s4_o,
    output logic signed [FRAC_BITS+9:0]   kgp_o,
    output logic signed [FRAC_BITS+7:0]   s3_o,
    output logic signed [FRAC_BITS+8:0]   m_o
);

    localparam int SW  = FRAC_BITS + 4;
    localparam int S2W = FRAC_BITS + 6;
    localparam int VW  = SW + 1;
    localparam int KW  = FRAC_BITS + 10;
    localparam int S3W = FRAC_BITS + 8;
    localparam int MW  = FRAC_BITS + 9;

    localparam logic signed [S2W-1:0] ONE_2 = S2W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [VW-1:0]  ONE_V = VW'(64'sd1 <<< FRAC_BITS);

    // stage 3: squares
    logic signed [2*SW-1:0] s_sq;
    logic signed [2*SW-1:0] t_sq;
    corey_pkg::flags_t      flg3_reg;
    logic signed [S2W-1:0]  s2_reg;
    logic signed [S2W-1:0]  t2_reg;
    logic signed [SW-1:0]   sd_reg;

    assign s_sq = s_i * s_i;
    assign t_sq = t_i * t_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flg3_reg <= '0;
        end else if (en) begin
            flg3_reg <= flg_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg <= S2W'(s_sq >>> FRAC_BITS);
            t2_reg <= S2W'(t_sq >>> FRAC_BITS);
            sd_reg <= s_i;
        end
    end

    // stage 4: s^4, s^3, (1-s)^2 (1-s^2), (1+2s)(1-s)^2
    logic signed [S2W-1:0]      u;
    logic signed [VW-1:0]       v;
    logic signed [2*S2W-1:0]    p_s4;
    logic signed [S2W+SW-1:0]   p_s3;
    logic signed [2*S2W-1:0]    p_kg;
    logic signed [VW+S2W-1:0]   p_m;
    corey_pkg::flags_t          flg4_reg;
    logic signed [KW-1:0]       s4_reg;
    logic signed [KW-1:0]       kgp_reg;
    logic signed [S3W-1:0]      s3_reg;
    logic signed [MW-1:0]       m_reg;

    assign u    = ONE_2 - s2_reg;
    assign v    = ONE_V + (VW'(sd_reg) <<< 1);
    assign p_s4 = s2_reg * s2_reg;
    assign p_s3 = s2_reg * sd_reg;
    assign p_kg = t2_reg * u;
    assign p_m  = v * t2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flg4_reg <= '0;
        end else if (en) begin
            flg4_reg <= flg3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_reg  <= KW'(p_s4 >>> FRAC_BITS);
            s3_reg  <= S3W'(p_s3 >>> FRAC_BITS);
            kgp_reg <= KW'(p_kg >>> FRAC_BITS);
            m_reg   <= MW'(p_m >>> FRAC_BITS);
        end
    end

    assign flg_o = flg4_reg;
    assign s4_o  = s4_reg;
    assign kgp_o = kgp_reg;
    assign s3_o  = s3_reg;
    assign m_o   = m_reg;

endmodule

@@ hw/rtl/corey_out.sv @@
// corey_out: stages 5-6, permeability clamps, derivative products and output register
// depends on corey_pkg
module corey_out #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  corey_pkg::flags_t                     flg_i,
    input  logic signed [FRAC_BITS+9:0]           s4_i,
    input  logic signed [FRAC_BITS+9:0]           kgp_i,
    input  logic signed [FRAC_BITS+7:0]           s3_i,
    input  logic signed [FRAC_BITS+8:0]           m_i,
    input  logic [corey_pkg::INV_REG_W-1:0]       inv_span,
    output logic                                  out_valid,
    output logic [corey_pkg::KR_W-1:0]            kr_liquid,
    output logic [corey_pkg::KR_W-1:0]            kr_gas,
    output logic [corey_pkg::DKL_W-1:0]           dkr_liquid,
    output logic [corey_pkg::DKG_W-1:0]           dkr_gas,
    output logic                                  range_error
);

    localparam int KW  = FRAC_BITS + 10;
    localparam int S3W = FRAC_BITS + 8;
    localparam int MW  = FRAC_BITS + 9;
    localparam int IW  = corey_pkg::INV_REG_W + 1;
    localparam int LW  = S3W + IW;
    localparam int GW  = MW + IW;
    localparam int QW  = FRAC_BITS + 36;

    localparam logic signed [KW-1:0] ONE_K  = KW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [QW-1:0] DL_MAX = QW'(64'sd2147483647);
    localparam logic signed [QW-1:0] DG_LIM = QW'(64'sd2147483648);
    localparam logic [corey_pkg::DKL_W-1:0] DL_SAT = {corey_pkg::DKL_W{1'b1}};
    localparam logic [corey_pkg::DKG_W-1:0] DG_SAT = {1'b1, {(corey_pkg::DKG_W-1){1'b0}}};

    // stage 5
    logic signed [KW-1:0]            kl_cl;
    logic signed [KW-1:0]            kg_cl;
    logic signed [LW-1:0]            pdl;
    logic signed [GW-1:0]            pdg;
    corey_pkg::flags_t               flg5_reg;
    logic [corey_pkg::KR_W-1:0]      kl_reg;
    logic [corey_pkg::KR_W-1:0]      kg_reg;
    logic signed [LW-1:0]            pdl_reg;
    logic signed [GW-1:0]            pdg_reg;

    always_comb begin
        if (s4_i < 0) begin
            kl_cl = '0;
        end else if (s4_i > ONE_K) begin
            kl_cl = ONE_K;
        end else begin
            kl_cl = s4_i;
        end
        if (kgp_i < 0) begin
            kg_cl = '0;
        end else if (kgp_i > ONE_K) begin
            kg_cl = ONE_K;
        end else begin
            kg_cl = kgp_i;
        end
    end

    assign pdl = s3_i * $signed({1'b0, inv_span});
    assign pdg = m_i * $signed({1'b0, inv_span});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flg5_reg <= '0;
        end else if (en) begin
            flg5_reg <= flg_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kl_reg  <= kl_cl[corey_pkg::KR_W-1:0];
            kg_reg  <= kg_cl[corey_pkg::KR_W-1:0];
            pdl_reg <= pdl;
            pdg_reg <= pdg;
        end
    end

    // stage 6: x4 and x2 scaling, floor shift, saturation, window gating
    logic signed [QW-1:0]            dl_ext;
    logic signed [QW-1:0]            dg_ext;
    logic signed [QW-1:0]            q4;
    logic signed [QW-1:0]            q2;
    logic signed [QW-1:0]            q2_neg;
    logic [corey_pkg::DKL_W-1:0]     dl_next;
    logic [corey_pkg::DKG_W-1:0]     dg_next;
    logic                            valid_reg;
    logic [corey_pkg::KR_W-1:0]      kr_liquid_reg;
    logic [corey_pkg::KR_W-1:0]      kr_gas_reg;
    logic [corey_pkg::DKL_W-1:0]     dkr_liquid_reg;
    logic [corey_pkg::DKG_W-1:0]     dkr_gas_reg;
    logic                            range_error_reg;

    assign dl_ext = QW'({pdl_reg, 2'b00});
    assign dg_ext = QW'({pdg_reg, 1'b0});
    assign q4     = dl_ext >>> FRAC_BITS;
    assign q2     = dg_ext >>> FRAC_BITS;
    assign q2_neg = -q2;

    always_comb begin
        if (!flg5_reg.window || q4 < 0) begin
            dl_next = '0;
        end else if (q4 > DL_MAX) begin
            dl_next = DL_SAT;
        end else begin
            dl_next = q4[corey_pkg::DKL_W-1:0];
        end
        if (!flg5_reg.window || q2 < 0) begin
            dg_next = '0;
        end else if (q2 >= DG_LIM) begin
            dg_next = DG_SAT;
        end else begin
            dg_next = q2_neg[corey_pkg::DKG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= flg5_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kr_liquid_reg   <= kl_reg;
            kr_gas_reg      <= kg_reg;
            dkr_liquid_reg  <= dl_next;
            dkr_gas_reg     <= dg_next;
            range_error_reg <= flg5_reg.err;
        end
    end

    assign out_valid   = valid_reg;
    assign kr_liquid   = kr_liquid_reg;
    assign kr_gas      = kr_gas_reg;
    assign dkr_liquid  = dkr_liquid_reg;
    assign dkr_gas     = dkr_gas_reg;
    assign range_error = range_error_reg;

endmodule

@@ hw/rtl/corey_relperm_eval_core.sv @@
// corey_relperm_eval_core: top level of the corey relative permeability evaluator
// depends on corey_pkg, corey_cfg, corey_scale, corey_poly, corey_out
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------------------
//  s_        | in        | s_tvalid/s_tready  | s_tdata[17:0] liquid_sat
//  m_        | out       | m_tvalid/m_tready  | m_tdata kr_liquid, kr_gas, dkr_liquid,
//            |           |                    |   dkr_gas; m_tuser range_error
//  cfg_wr_   | in        | cfg_wr_en only     | cfg_wr_addr register index, cfg_wr_data
//
// six register stages; one request enters per clock while the output register is not stalled
// the stage count is set by the multiplier chain s -> s^2 -> s^3/s^4 -> x inv_span
// every stage advances together whenever the output register is empty or being taken,
// so a stalled output holds the whole pipe and nothing is dropped or repeated
// reset (aresetn low, synchronous) clears the valid bits and loads the default registers
// configuration is read directly by the stages and must only change while the pipe is empty
module corey_relperm_eval_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    // input requests
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [23:0]   s_tdata,      // [17:0] liquid_sat, [23:18] zero
    // results
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,      // [16:0] kr_liquid, [33:17] kr_gas,
                                        // [64:34] dkr_liquid, [96:65] dkr_gas, [103:97] zero
    output logic [0:0]    m_tuser,      // [0] range_error
    // register writes
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_wr_addr,
    input  logic [23:0]   cfg_wr_data
);

    logic [corey_pkg::RESID_W-1:0]   resid_liquid;
    logic [corey_pkg::RESID_W-1:0]   resid_gas;
    logic [corey_pkg::INV_REG_W-1:0] inv_span;

    // pipe advance: output register free or being emptied this cycle
    logic                            en;

    corey_pkg::flags_t               flg_scale;
    corey_pkg::flags_t               flg_poly;
    logic signed [FRAC_BITS+3:0]     s_val;
    logic signed [FRAC_BITS+3:0]     t_val;
    logic signed [FRAC_BITS+9:0]     s4_val;
    logic signed [FRAC_BITS+9:0]     kgp_val;
    logic signed [FRAC_BITS+7:0]     s3_val;
    logic signed [FRAC_BITS+8:0]     m_val;

    logic                            out_valid;
    logic [corey_pkg::KR_W-1:0]      kr_liquid;
    logic [corey_pkg::KR_W-1:0]      kr_gas;
    logic [corey_pkg::DKL_W-1:0]     dkr_liquid;
    logic [corey_pkg::DKG_W-1:0]     dkr_gas;
    logic                            range_error;

    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    corey_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_addr  (cfg_wr_addr),
        .cfg_wr_data  (cfg_wr_data),
        .resid_liquid (resid_liquid),
        .resid_gas    (resid_gas),
        .inv_span     (inv_span)
    );

    // stages 1-2: effective saturation and window / range flags
    corey_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .sat          ($signed(s_tdata[corey_pkg::SAT_W-1:0])),
        .resid_liquid (resid_liquid),
        .resid_gas    (resid_gas),
        .inv_span     (inv_span),
        .flg_o        (flg_scale),
        .s_o          (s_val),
        .t_o          (t_val)
    );

    // stages 3-4: polynomial terms
    corey_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .flg_i   (flg_scale),
        .s_i     (s_val),
        .t_i     (t_val),
        .flg_o   (flg_poly),
        .s4_o    (s4_val),
        .kgp_o   (kgp_val),
        .s3_o    (s3_val),
        .m_o     (m_val)
    );

    // stages 5-6: clamps, derivative scaling, output register
    corey_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .flg_i       (flg_poly),
        .s4_i        (s4_val),
        .kgp_i       (kgp_val),
        .s3_i        (s3_val),
        .m_i         (m_val),
        .inv_span    (inv_span),
        .out_valid   (out_valid),
        .kr_liquid   (kr_liquid),
        .kr_gas      (kr_gas),
        .dkr_liquid  (dkr_liquid),
        .dkr_gas     (dkr_gas),
        .range_error (range_error)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {7'b0, dkr_gas, dkr_liquid, kr_gas, kr_liquid};
    assign m_tuser  = range_error;

endmodule

@@ hw/rtl/corey_chk.sv @@
// corey_chk: port-level checks for corey_relperm_eval_core, attached by bind
// depends on corey_relperm_eval_core port names only
module corey_chk (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [103:0]  m_tdata,
    input logic [0:0]    m_tuser
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds the whole pipe, so no new request is taken
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while result stalled");

    // out-of-range saturation lies outside the derivative window
    a_err_no_deriv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[64:34] == 31'd0 && m_tdata[96:65] == 32'd0)
        else $error("derivative nonzero on range error");

    // gas derivative never positive
    a_dg_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[96] || m_tdata[96:65] == 32'd0)
        else $error("gas derivative positive");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind corey_relperm_eval_core corey_chk u_chk (.*);
